// ===== src/grid_maze_router_top_macros.svh =====
// ----------------------------------------------------------------------------
// grid_maze_router_top_macros
// Assertion macros for the grid maze router.
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_ROUTER_TOP_MACROS_SVH
`define GRID_MAZE_ROUTER_TOP_MACROS_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define GMR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("grid maze router check failed");
// Check that a condition implies a consequence in the next cycle.
`define GMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid maze router check failed");
`else
`define GMR_ASSERT_ALWAYS(label, clk, rst, cond)
`define GMR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/gmr_pkg.sv =====
// ----------------------------------------------------------------------------
// gmr_pkg
// Shared codes and controller/datapath interface types of the maze router.
// ----------------------------------------------------------------------------
package gmr_pkg;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_ROUTE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   // Direction in which a cell was reached from its parent.
   localparam logic [1:0] DIR_YP = 2'd0;
   localparam logic [1:0] DIR_XP = 2'd1;
   localparam logic [1:0] DIR_XM = 2'd2;
   localparam logic [1:0] DIR_YM = 2'd3;

   localparam logic [6:0] CFG_DIM_RESET = 7'd64;
   localparam logic       CSR_ROWS      = 1'b0;
   localparam logic       CSR_COLS      = 1'b1;

   typedef struct packed {
      logic take;
      logic rst_wr;
      logic wr_cell;
      logic rd_path;
      logic rd_lat;
      logic rinit;
      logic fail;
      logic single;
      logic seed;
      logic pop;
      logic cur_lat;
      logic d_inc;
      logic nb_rd;
      logic nb_take;
      logic trace_init;
      logic tr_put;
      logic tr_step;
      logic clr_start;
      logic clr_rd;
      logic clr_wr;
      logic rsp_load;
   } gmr_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       src_in;
      logic       src_eq_tgt;
      logic       idx_ok;
      logic       q_empty;
      logic       nb_ok;
      logic       nb_free;
      logic       nb_hit;
      logic       d_last;
      logic       at_src;
      logic       clr_done;
      logic       sw_last;
      logic       rsp_free;
   } gmr_stat_type;

endpackage

// ===== src/gmr_ram.sv =====
// ----------------------------------------------------------------------------
// gmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/gmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmr_ctrl
// Sequencer for cell writes, path reads and breadth-first routes.
// ----------------------------------------------------------------------------
module gmr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gmr_pkg::gmr_stat_type stat,
   output gmr_pkg::gmr_cmd_type  cmd
);
   import gmr_pkg::*;

   localparam logic [3:0] S_RST   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_RDW   = 4'd3;
   localparam logic [3:0] S_RINIT = 4'd4;
   localparam logic [3:0] S_POP   = 4'd5;
   localparam logic [3:0] S_POPW  = 4'd6;
   localparam logic [3:0] S_NB    = 4'd7;
   localparam logic [3:0] S_NCHK  = 4'd8;
   localparam logic [3:0] S_TR    = 4'd9;
   localparam logic [3:0] S_TRW   = 4'd10;
   localparam logic [3:0] S_CLR   = 4'd11;
   localparam logic [3:0] S_CLRW  = 4'd12;
   localparam logic [3:0] S_RESP  = 4'd13;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_RST: begin
            cmd.rst_wr = 1'b1;
            if (stat.sw_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.action)
               ACT_WRITE: begin
                  cmd.wr_cell = stat.src_in;
                  state_in    = S_RESP;
               end
               ACT_ROUTE: state_in = S_RINIT;
               ACT_READ: begin
                  if (stat.idx_ok) begin
                     cmd.rd_path = 1'b1;
                     state_in    = S_RDW;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_RDW: begin
            cmd.rd_lat = 1'b1;
            state_in   = S_RESP;
         end
         S_RINIT: begin
            cmd.rinit = 1'b1;
            if (!stat.src_in) begin
               cmd.fail = 1'b1;
               state_in = S_RESP;
            end else if (stat.src_eq_tgt) begin
               cmd.single = 1'b1;
               state_in   = S_RESP;
            end else begin
               cmd.seed = 1'b1;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (stat.q_empty) begin
               cmd.fail      = 1'b1;
               cmd.clr_start = 1'b1;
               state_in      = S_CLR;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            cmd.cur_lat = 1'b1;
            state_in    = S_NB;
         end
         S_NB: begin
            if (stat.nb_ok) begin
               cmd.nb_rd = 1'b1;
               state_in  = S_NCHK;
            end else if (stat.d_last) begin
               state_in = S_POP;
            end else begin
               cmd.d_inc = 1'b1;
            end
         end
         S_NCHK: begin
            if (stat.nb_free && stat.nb_hit) begin
               cmd.nb_take    = 1'b1;
               cmd.trace_init = 1'b1;
               state_in       = S_TR;
            end else begin
               cmd.nb_take = stat.nb_free;
               if (stat.d_last) begin
                  state_in = S_POP;
               end else begin
                  cmd.d_inc = 1'b1;
                  state_in  = S_NB;
               end
            end
         end
         S_TR: begin
            cmd.tr_put = 1'b1;
            if (stat.at_src) begin
               cmd.clr_start = 1'b1;
               state_in      = S_CLR;
            end else begin
               state_in = S_TRW;
            end
         end
         S_TRW: begin
            cmd.tr_step = 1'b1;
            state_in    = S_TR;
         end
         S_CLR: begin
            if (stat.clr_done) begin
               state_in = S_RESP;
            end else begin
               cmd.clr_rd = 1'b1;
               state_in   = S_CLRW;
            end
         end
         S_CLRW: begin
            cmd.clr_wr = 1'b1;
            state_in   = S_CLR;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== src/gmr_dp.sv =====
// ----------------------------------------------------------------------------
// gmr_dp
// Maze router datapath: grid memories, wave queue, trace and result register.
// ----------------------------------------------------------------------------
module gmr_dp #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_action,
   input  logic [5:0]            req_first_x,
   input  logic [5:0]            req_first_y,
   input  logic [5:0]            req_target_x,
   input  logic [5:0]            req_target_y,
   input  logic                  req_blocked_bit,
   input  logic [11:0]           req_path_index,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [6:0]            csr_wr_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic [12:0]           rsp_path_length,
   output logic [5:0]            rsp_cell_x,
   output logic [5:0]            rsp_cell_y,
   input  gmr_pkg::gmr_cmd_type  cmd,
   output gmr_pkg::gmr_stat_type stat
);
   import gmr_pkg::*;

   localparam int XW    = $clog2(MAX_COLS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int NCELL = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(NCELL);
   localparam int CNW   = $clog2(NCELL + 1);
   localparam int RDW   = $clog2(MAX_ROWS + 1);
   localparam int CDW   = $clog2(MAX_COLS + 1);
   localparam int PW    = XW + YW;

   // Request and configuration
   logic [1:0]  act_ff;
   logic [5:0]  fx_ff, fy_ff, tx_ff, ty_ff;
   logic        bit_ff;
   logic [11:0] idx_ff;
   logic [6:0]  rows_ff, cols_ff;
   logic [RDW-1:0] rows_eff;
   logic [CDW-1:0] cols_eff;

   // Search and trace state
   logic [XW-1:0]  cx_ff, nx_ff, trx_ff, nbx;
   logic [YW-1:0]  cy_ff, ny_ff, try_ff, nby;
   logic [1:0]     d_ff;
   logic [CNW-1:0] head_ff, tail_ff, sw_ff, count_ff;
   logic           nb_ok;

   // Result and output register
   logic        res_status_ff;
   logic [5:0]  res_x_ff, res_y_ff;
   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   logic [12:0] rsp_len_ff;
   logic [5:0]  rsp_x_ff, rsp_y_ff;

   logic [XW-1:0] sx;
   logic [YW-1:0] sy;

   // Memory ports
   logic          blk_we, blk_wd, blk_rd;
   logic          fnd_we, fnd_wd, fnd_rd;
   logic          par_we;
   logic [1:0]    par_rd;
   logic          q_we, path_we;
   logic [AW-1:0] blk_wa, fnd_wa, nb_addr, q_wa, q_ra, path_wa, path_ra, tr_addr;
   logic [PW-1:0] q_wd, q_rd, path_wd, path_rd;

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
      cell_addr = AW'(32'(y) * 32'(MAX_COLS) + 32'(x));
   endfunction

   always_comb begin
      if (rows_ff == 7'd0) begin
         rows_eff = RDW'(1);
      end else if (16'(rows_ff) > 16'(MAX_ROWS)) begin
         rows_eff = RDW'(MAX_ROWS);
      end else begin
         rows_eff = RDW'(rows_ff);
      end
      if (cols_ff == 7'd0) begin
         cols_eff = CDW'(1);
      end else if (16'(cols_ff) > 16'(MAX_COLS)) begin
         cols_eff = CDW'(MAX_COLS);
      end else begin
         cols_eff = CDW'(cols_ff);
      end
   end

   assign sx = XW'(16'(fx_ff));
   assign sy = YW'(16'(fy_ff));

   // Neighbor of the current cell in direction d
   always_comb begin
      nbx   = cx_ff;
      nby   = cy_ff;
      nb_ok = 1'b0;
      case (d_ff)
         DIR_YP: begin
            nb_ok = (16'(cy_ff) + 16'd1) < 16'(rows_eff);
            nby   = cy_ff + YW'(1);
         end
         DIR_XP: begin
            nb_ok = (16'(cx_ff) + 16'd1) < 16'(cols_eff);
            nbx   = cx_ff + XW'(1);
         end
         DIR_XM: begin
            nb_ok = (cx_ff != '0);
            nbx   = cx_ff - XW'(1);
         end
         default: begin
            nb_ok = (cy_ff != '0);
            nby   = cy_ff - YW'(1);
         end
      endcase
   end

   assign nb_addr = cell_addr(nbx, nby);
   assign tr_addr = cell_addr(trx_ff, try_ff);

   // Memory port selection
   always_comb begin
      blk_we = 1'b0;
      blk_wa = tr_addr;
      blk_wd = 1'b1;
      if (cmd.rst_wr) begin
         blk_we = 1'b1;
         blk_wa = sw_ff[AW-1:0];
         blk_wd = 1'b0;
      end else if (cmd.wr_cell) begin
         blk_we = 1'b1;
         blk_wa = cell_addr(sx, sy);
         blk_wd = bit_ff;
      end else if (cmd.single) begin
         blk_we = 1'b1;
         blk_wa = cell_addr(sx, sy);
      end else if (cmd.tr_put) begin
         blk_we = 1'b1;
      end

      fnd_we = 1'b0;
      fnd_wa = cell_addr(nx_ff, ny_ff);
      fnd_wd = 1'b1;
      if (cmd.rst_wr) begin
         fnd_we = 1'b1;
         fnd_wa = sw_ff[AW-1:0];
         fnd_wd = 1'b0;
      end else if (cmd.seed) begin
         fnd_we = 1'b1;
         fnd_wa = cell_addr(sx, sy);
      end else if (cmd.nb_take) begin
         fnd_we = 1'b1;
      end else if (cmd.clr_wr) begin
         fnd_we = 1'b1;
         fnd_wa = cell_addr(q_rd[XW-1:0], q_rd[PW-1:XW]);
         fnd_wd = 1'b0;
      end

      q_we = cmd.seed | cmd.nb_take;
      q_wa = cmd.seed ? '0 : tail_ff[AW-1:0];
      q_wd = cmd.seed ? {sy, sx} : {ny_ff, nx_ff};
      q_ra = cmd.clr_rd ? sw_ff[AW-1:0] : head_ff[AW-1:0];

      par_we = cmd.nb_take;

      path_we = cmd.single | cmd.tr_put;
      path_wa = cmd.single ? '0 : count_ff[AW-1:0];
      path_wd = cmd.single ? {sy, sx} : {try_ff, trx_ff};
      path_ra = AW'(idx_ff);
   end

   gmr_ram #(.WIDTH(1), .DEPTH(NCELL)) u_blk (
      .clock(clock), .wr_en(blk_we), .wr_addr(blk_wa), .wr_data(blk_wd),
      .rd_addr(nb_addr), .rd_data(blk_rd));

   gmr_ram #(.WIDTH(1), .DEPTH(NCELL)) u_fnd (
      .clock(clock), .wr_en(fnd_we), .wr_addr(fnd_wa), .wr_data(fnd_wd),
      .rd_addr(nb_addr), .rd_data(fnd_rd));

   gmr_ram #(.WIDTH(2), .DEPTH(NCELL)) u_par (
      .clock(clock), .wr_en(par_we), .wr_addr(cell_addr(nx_ff, ny_ff)), .wr_data(d_ff),
      .rd_addr(tr_addr), .rd_data(par_rd));

   gmr_ram #(.WIDTH(PW), .DEPTH(NCELL)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   gmr_ram #(.WIDTH(PW), .DEPTH(NCELL)) u_path (
      .clock(clock), .wr_en(path_we), .wr_addr(path_wa), .wr_data(path_wd),
      .rd_addr(path_ra), .rd_data(path_rd));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= CFG_DIM_RESET;
         cols_ff      <= CFG_DIM_RESET;
         sw_ff        <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         d_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ROWS) begin
               rows_ff <= csr_wr_data;
            end else begin
               cols_ff <= csr_wr_data;
            end
         end
         if (cmd.rst_wr || cmd.clr_wr) begin
            sw_ff <= sw_ff + CNW'(1);
         end else if (cmd.clr_start) begin
            sw_ff <= '0;
         end
         if (cmd.single) begin
            count_ff <= CNW'(1);
         end else if (cmd.rinit) begin
            count_ff <= '0;
         end else if (cmd.tr_put) begin
            count_ff <= count_ff + CNW'(1);
         end
         if (cmd.seed) begin
            head_ff <= '0;
            tail_ff <= CNW'(1);
         end else begin
            if (cmd.pop) begin
               head_ff <= head_ff + CNW'(1);
            end
            if (cmd.nb_take) begin
               tail_ff <= tail_ff + CNW'(1);
            end
         end
         if (cmd.cur_lat) begin
            d_ff <= DIR_YP;
         end else if (cmd.d_inc) begin
            d_ff <= d_ff + 2'd1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         act_ff        <= req_action;
         fx_ff         <= req_first_x;
         fy_ff         <= req_first_y;
         tx_ff         <= req_target_x;
         ty_ff         <= req_target_y;
         bit_ff        <= req_blocked_bit;
         idx_ff        <= req_path_index;
         res_status_ff <= 1'b0;
         res_x_ff      <= '0;
         res_y_ff      <= '0;
      end else begin
         if (cmd.fail) begin
            res_status_ff <= 1'b1;
         end
         if (cmd.rd_lat) begin
            res_x_ff <= 6'(16'(path_rd[XW-1:0]));
            res_y_ff <= 6'(16'(path_rd[PW-1:XW]));
         end
      end
      if (cmd.cur_lat) begin
         cx_ff <= q_rd[XW-1:0];
         cy_ff <= q_rd[PW-1:XW];
      end
      if (cmd.nb_rd) begin
         nx_ff <= nbx;
         ny_ff <= nby;
      end
      if (cmd.trace_init) begin
         trx_ff <= nx_ff;
         try_ff <= ny_ff;
      end else if (cmd.tr_step) begin
         case (par_rd)
            DIR_YP:  try_ff <= try_ff - YW'(1);
            DIR_XP:  trx_ff <= trx_ff - XW'(1);
            DIR_XM:  trx_ff <= trx_ff + XW'(1);
            default: try_ff <= try_ff + YW'(1);
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_len_ff    <= 13'(count_ff);
         rsp_x_ff      <= res_x_ff;
         rsp_y_ff      <= res_y_ff;
      end
   end

   always_comb begin
      stat.action     = act_ff;
      stat.src_in     = (16'(fx_ff) < 16'(cols_eff)) && (16'(fy_ff) < 16'(rows_eff));
      stat.src_eq_tgt = (fx_ff == tx_ff) && (fy_ff == ty_ff);
      stat.idx_ok     = 32'(idx_ff) < 32'(count_ff);
      stat.q_empty    = (head_ff == tail_ff);
      stat.nb_ok      = nb_ok;
      stat.nb_free    = !blk_rd && !fnd_rd;
      stat.nb_hit     = (16'(nx_ff) == 16'(tx_ff)) && (16'(ny_ff) == 16'(ty_ff));
      stat.d_last     = (d_ff == DIR_YM);
      stat.at_src     = (trx_ff == sx) && (try_ff == sy);
      stat.clr_done   = (sw_ff == tail_ff);
      stat.sw_last    = (sw_ff[AW-1:0] == AW'(NCELL - 1));
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_cell_x      = rsp_x_ff;
   assign rsp_cell_y      = rsp_y_ff;
endmodule

// ===== src/grid_maze_router_top.sv =====
// Sequence: a cell write is dispatched and answered; a path read adds a path memory read.
// A route pops each wavefront cell, reads and checks each in-grid neighbor, skips each edge
// direction off the grid, then puts each traced path cell and clears each visited cell.
// Throughput: one request in work at a time; the next is taken while a response waits.
// Reset: synchronous; a clearing pass over all MAX_ROWS*MAX_COLS cells frees the grid first.
// ----------------------------------------------------------------------------
// grid_maze_router_top
// Lee-style breadth-first maze router over a grid of blocked and free cells.
// ----------------------------------------------------------------------------
`include "grid_maze_router_top_macros.svh"

module grid_maze_router_top #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_first_x,
   input  logic [5:0]  req_first_y,
   input  logic [5:0]  req_target_x,
   input  logic [5:0]  req_target_y,
   input  logic        req_blocked_bit,
   input  logic [11:0] req_path_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [12:0] rsp_path_length,
   output logic [5:0]  rsp_cell_x,
   output logic [5:0]  rsp_cell_y,
   // configuration: index 0 grid rows, index 1 grid columns
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [6:0]  csr_wr_data
);
   import gmr_pkg::*;

   gmr_cmd_type  cmd;
   gmr_stat_type stat;

   // Sequencer: walks each request through its phases
   gmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: grid memories, wave queue, path store, response register
   gmr_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .req_blocked_bit (req_blocked_bit),
      .req_path_index  (req_path_index),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_path_length (rsp_path_length),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .cmd             (cmd),
      .stat            (stat)
   );

   // Never overwrite a response that is still waiting
   `GMR_ASSERT_ALWAYS(a_no_rsp_overrun, clock, reset, !cmd.rsp_load || stat.rsp_free)
   // A failed route always reports an empty path
   `GMR_ASSERT_ALWAYS(a_fail_empty, clock, reset, !(rsp_valid && rsp_status) || (rsp_path_length == 13'd0))
   // Hold off the next request once one is taken
   `GMR_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall)
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives cell writes, routes and path reads into the grid maze router and
// compares every response with a breadth-first routing predictor kept in the
// bench, over several grid sizes and handshake idling patterns.
// ----------------------------------------------------------------------------
module testbench;
   import gmr_pkg::*;

   localparam int NCOLS  = 64;
   localparam int NROWS  = 64;
   localparam int NCELLS = NCOLS * NROWS;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  first_x;
      logic [5:0]  first_y;
      logic [5:0]  target_x;
      logic [5:0]  target_y;
      logic        blocked_bit;
      logic [11:0] path_index;
   } request_type;

   typedef struct packed {
      logic        status;
      logic [12:0] path_length;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
   } response_type;

   localparam int REQ_W = $bits(request_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [5:0]  req_first_x = '0;
   logic [5:0]  req_first_y = '0;
   logic [5:0]  req_target_x = '0;
   logic [5:0]  req_target_y = '0;
   logic        req_blocked_bit = 1'b0;
   logic [11:0] req_path_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic [12:0] rsp_path_length;
   logic [5:0]  rsp_cell_x;
   logic [5:0]  rsp_cell_y;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   grid_maze_router_top u_top (.*);

   // clock: 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: grid map, last path and grid size
   logic        blocked_cells [NCELLS];
   logic        seen_cells [NCELLS];
   logic [1:0]  came_from [NCELLS];
   int          wavefront [NCELLS];
   int          route_cells [NCELLS];
   int          route_len;
   logic [6:0]  rows_reg;
   logic [6:0]  cols_reg;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int           error_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_off_cycles = 0;
   bit           hold_off_arm = 1'b0;
   bit           hold_off_active = 1'b0;

   function automatic int clamp_size(logic [6:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Breadth-first route from source to target; returns status bit.
   function automatic logic route_net(int sx, int sy, int tx, int ty);
      int rows, cols, src, tgt, head, tail, cur, cx, cy, nx, ny, n, c, k;
      bit hit;
      rows = clamp_size(rows_reg, NROWS);
      cols = clamp_size(cols_reg, NCOLS);
      route_len = 0;
      if (sx >= cols || sy >= rows) return 1'b1;
      src = sy * NCOLS + sx;
      if (sx == tx && sy == ty) begin
         route_cells[0] = src;
         route_len = 1;
         blocked_cells[src] = 1'b1;
         return 1'b0;
      end
      hit = 0; tgt = 0; head = 0; tail = 0;
      seen_cells[src] = 1'b1;
      wavefront[tail++] = src;
      while (head < tail && !hit) begin
         cur = wavefront[head++];
         cx = cur % NCOLS;
         cy = cur / NCOLS;
         for (int d = 0; d < 4 && !hit; d++) begin
            nx = cx; ny = cy;
            if (d == DIR_YP) begin
               if (cy + 1 >= rows) continue;
               ny = cy + 1;
            end else if (d == DIR_XP) begin
               if (cx + 1 >= cols) continue;
               nx = cx + 1;
            end else if (d == DIR_XM) begin
               if (cx == 0) continue;
               nx = cx - 1;
            end else begin
               if (cy == 0) continue;
               ny = cy - 1;
            end
            n = ny * NCOLS + nx;
            if (blocked_cells[n] || seen_cells[n]) continue;
            seen_cells[n] = 1'b1;
            came_from[n] = d[1:0];
            if (tail < NCELLS) wavefront[tail++] = n;
            if (nx == tx && ny == ty) begin
               hit = 1; tgt = n;
            end
         end
      end
      if (hit) begin
         c = tgt; k = 0;
         while (k < NCELLS) begin
            route_cells[k++] = c;
            if (c == src) break;
            case (came_from[c])
               DIR_YP: c -= NCOLS;
               DIR_XP: c -= 1;
               DIR_XM: c += 1;
               default: c += NCOLS;
            endcase
            if (c < 0 || c >= NCELLS) break;
         end
         route_len = k;
         for (int i = 0; i < k; i++) blocked_cells[route_cells[i]] = 1'b1;
      end
      foreach (seen_cells[i]) seen_cells[i] = 1'b0;
      return hit ? 1'b0 : 1'b1;
   endfunction

   function automatic response_type predict_response(request_type r);
      response_type o;
      int rows, cols;
      o = '0;
      rows = clamp_size(rows_reg, NROWS);
      cols = clamp_size(cols_reg, NCOLS);
      case (r.action)
         ACT_WRITE:
            if (r.first_x < cols && r.first_y < rows)
               blocked_cells[r.first_y * NCOLS + r.first_x] = r.blocked_bit;
         ACT_ROUTE:
            o.status = route_net(r.first_x, r.first_y, r.target_x, r.target_y);
         ACT_READ:
            if (r.path_index < route_len) begin
               o.cell_x = 6'(route_cells[r.path_index] % NCOLS);
               o.cell_y = 6'(route_cells[r.path_index] / NCOLS);
            end
         default: ;
      endcase
      o.path_length = 13'(route_len);
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic queue_req(request_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   // Driver: present the head of the pending queue, advance on acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps = {expected_rsps, predict_response(pending_reqs.pop_front())};
         end
         // hold a stalled request; otherwise pick the next one or idle
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid       <= 1'b1;
               req_action      <= pending_reqs[0].action;
               req_first_x     <= pending_reqs[0].first_x;
               req_first_y     <= pending_reqs[0].first_y;
               req_target_x    <= pending_reqs[0].target_x;
               req_target_y    <= pending_reqs[0].target_y;
               req_blocked_bit <= pending_reqs[0].blocked_bit;
               req_path_index  <= pending_reqs[0].path_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here once the stimulus arms it.
   initial begin
      wait (hold_off_arm);
      @(posedge clock);
      hold_off_active <= 1'b1;
      for (hold_off_cycles = 0; hold_off_cycles < 300; hold_off_cycles++) @(posedge clock);
      hold_off_active <= 1'b0;
   end

   // Monitor: check accepted responses, drive receiver stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response count", 1, 0);
            end else begin
               response_type want;
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_path_length !== want.path_length)
                  report_mismatch("path_length", rsp_path_length, want.path_length);
               if (rsp_cell_x !== want.cell_x)
                  report_mismatch("cell_x", rsp_cell_x, want.cell_x);
               if (rsp_cell_y !== want.cell_y)
                  report_mismatch("cell_y", rsp_cell_y, want.cell_y);
            end
         end
         if (hold_off_active) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic request_type make_req(logic [1:0] a, int fx, int fy, int tx, int ty,
                                            int b, int idx);
      request_type r;
      r.action = a; r.first_x = 6'(fx); r.first_y = 6'(fy); r.target_x = 6'(tx);
      r.target_y = 6'(ty); r.blocked_bit = 1'(b); r.path_index = 12'(idx);
      return r;
   endfunction

   task automatic write_size(logic idx, logic [6:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      if (idx == CSR_ROWS) rows_reg = val; else cols_reg = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain_phase();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random request biased toward the in-use grid so routes succeed often.
   function automatic request_type random_req(int rows, int cols);
      request_type r;
      int p;
      r = REQ_W'({$urandom, $urandom});
      p = $urandom_range(99);
      if (p < 5) r.action = ACT_NOP;
      else if (p < 45) r.action = ACT_WRITE;
      else if (p < 70) r.action = ACT_ROUTE;
      else r.action = ACT_READ;
      if ($urandom_range(9) != 0) begin
         r.first_x  = 6'($urandom_range(cols - 1));
         r.first_y  = 6'($urandom_range(rows - 1));
         r.target_x = 6'($urandom_range(cols - 1));
         r.target_y = 6'($urandom_range(rows - 1));
      end
      if ($urandom_range(4) != 0) r.path_index = 12'($urandom_range(15));
      return r;
   endfunction

   task automatic random_phase(logic [6:0] rows_v, logic [6:0] cols_v, int count);
      int rows, cols;
      write_size(CSR_ROWS, rows_v);
      write_size(CSR_COLS, cols_v);
      rows = clamp_size(rows_v, NROWS);
      cols = clamp_size(cols_v, NCOLS);
      repeat (count) queue_req(random_req(rows, cols));
      drain_phase();
   endtask

   initial begin
      foreach (blocked_cells[i]) begin
         blocked_cells[i] = 1'b0; seen_cells[i] = 1'b0; came_from[i] = '0;
      end
      route_len = 0;
      rows_reg = CFG_DIM_RESET;
      cols_reg = CFG_DIM_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: full grid, extreme fields and each special case
      send_idle_pct = 28; recv_idle_pct = 87;
      queue_req(make_req(ACT_READ, 0, 0, 0, 0, 0, 0));        // empty path
      queue_req(make_req(ACT_ROUTE, 0, 0, 63, 63, 0, 0));     // corner to corner
      queue_req(make_req(ACT_READ, 0, 0, 0, 0, 0, 0));
      queue_req(make_req(ACT_READ, 63, 63, 63, 63, 1, 126));  // source cell
      queue_req(make_req(ACT_READ, 0, 0, 0, 0, 0, 4095));     // past the end
      queue_req(make_req(ACT_ROUTE, 0, 0, 5, 5, 0, 0));       // blocked source
      queue_req(make_req(ACT_ROUTE, 10, 10, 0, 0, 0, 0));     // blocked target
      queue_req(make_req(ACT_ROUTE, 7, 7, 7, 7, 0, 0));       // source is target
      queue_req(make_req(ACT_WRITE, 7, 7, 0, 0, 0, 0));       // free it again
      queue_req(make_req(ACT_WRITE, 20, 21, 0, 0, 1, 0));
      queue_req(make_req(ACT_WRITE, 20, 21, 0, 0, 0, 0));
      queue_req(make_req(ACT_NOP, 63, 63, 63, 63, 1, 4095));  // unused action
      drain_phase();

      // small grid: out-of-grid write, source and target
      write_size(CSR_ROWS, 7'd3);
      write_size(CSR_COLS, 7'd4);
      queue_req(make_req(ACT_WRITE, 4, 0, 0, 0, 1, 0));
      queue_req(make_req(ACT_WRITE, 0, 3, 0, 0, 1, 0));
      queue_req(make_req(ACT_ROUTE, 5, 1, 0, 0, 0, 0));
      queue_req(make_req(ACT_ROUTE, 0, 1, 3, 2, 0, 0));
      queue_req(make_req(ACT_READ, 0, 0, 0, 0, 0, 1));
      queue_req(make_req(ACT_ROUTE, 0, 2, 9, 2, 0, 0));
      drain_phase();

      // long hold-off on the receiver while requests keep coming
      hold_off_arm = 1'b1;
      random_phase(7'd0, 7'd127, 10);   // clamps to 1 row, 64 columns
      send_idle_pct = 87; recv_idle_pct = 28;
      random_phase(7'd8, 7'd8, 30);
      random_phase(7'd127, 7'd0, 10);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(7'd5, 7'd12, 30);
      random_phase(7'd64, 7'd64, 20);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // Generous bound: reset clearing, a few full-grid routes, stalls.
   initial begin
      #400ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/gmr_pkg.sv
src/gmr_ram.sv
src/gmr_ctrl.sv
src/gmr_dp.sv
src/grid_maze_router_top.sv
bench/testbench.sv
